// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

  localparam int MAX_PARTS   = 16;
  localparam int PART_BITS   = $clog2(MAX_PARTS);
  localparam int CNT_BITS    = PART_BITS + 1;
  localparam int ADDR_BITS   = 2 * PART_BITS;
  localparam int CELLS       = MAX_PARTS * MAX_PARTS;
  localparam int WEIGHT_BITS = 40;
  localparam int BEST_BITS   = WEIGHT_BITS + 1;
  localparam int VERTEX_BITS = 32;
  localparam int DEG_BITS    = 32;

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_LOAD   = 3'd1;
  localparam logic [2:0] CMD_EDGE   = 3'd2;
  localparam logic [2:0] CMD_SELECT = 3'd3;
  localparam logic [2:0] CMD_SPLIT  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  part_index;
    logic [4:0]  part_count;
    logic [31:0] range_first;
    logic [31:0] range_last;
    logic [31:0] edge_src;
    logic [31:0] edge_dst;
    logic [31:0] dst_degree;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        pair_found;
    logic [3:0]  first_part;
    logic [3:0]  second_part;
    logic [40:0] best_weight;
  } res_word_t;

  // range search result handed from the range table to the sequencer
  typedef struct packed {
    logic                 done;
    logic                 has_from;
    logic                 has_to;
    logic [PART_BITS-1:0] from_part;
    logic [PART_BITS-1:0] to_part;
  } search_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_EDGE_SCAN, S_EDGE_RD, S_EDGE_WR,
    S_SEL_RD, S_SEL_EV,
    S_SPL_RD, S_SPL_W0, S_SPL_W1, S_SPL_W2, S_SPL_W3,
    S_LINK0, S_LINK1, S_LINK2, S_DONE
  } state_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [PART_BITS-1:0] r,
                                                      input logic [PART_BITS-1:0] c);
    return {r, c};
  endfunction

endpackage

// ===== rtl/core/partition_pair_scheduler.sv =====
// Partition pair scheduler. Takes one command word at a time on cmd_* and
// returns exactly one result word on res_*. The weight matrix sits in a
// 256-entry synchronous RAM with two read ports; start, edge, select and
// split run short read and write sequences on it. Per word: load writes
// the range table; edge compares one range per cycle, then reads and writes
// one cell, skipping the cell when an endpoint is outside or both land in
// one partition; select reads and compares each pair in turn; split reads
// a cell pair, then makes up to four writes, per index, then writes the two
// link cells and the diagonal; start runs a clearing pass over the RAM.
// After reset the same clearing pass runs before the first command is taken.
// A new command may be accepted while a finished result still waits on
// res_*; it then completes once that result has been taken.
module partition_pair_scheduler (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  pps_pkg::cmd_word_t  cmd_word,
  output logic                res_valid,
  input  logic                res_ready,
  output pps_pkg::res_word_t  res_word
);
  import pps_pkg::*;

  state_t state, state_next;

  // RAM ports
  logic                   we;
  logic [ADDR_BITS-1:0]   waddr, raddr0, raddr1;
  logic [WEIGHT_BITS-1:0] wdata, rd0, rd1;

  // range table control
  logic    rt_wr, rt_start;
  search_t srch;

  // datapath registers
  logic [CNT_BITS-1:0]    active;
  logic [ADDR_BITS-1:0]   clr;
  logic                   clr_reply;
  res_word_t              pend;
  logic [CNT_BITS-1:0]    si, sj, sn;
  logic [PART_BITS-1:0]   sp;
  logic [WEIGHT_BITS-1:0] wa, wb;
  logic [DEG_BITS-1:0]    deg;
  logic [BEST_BITS-1:0]   pair_sum;
  logic [WEIGHT_BITS:0]   edge_sum;
  logic                   accept;
  logic [1:0]             acc_status;  // status known at accept time

  logic [PART_BITS-1:0] ix, jx, nx;
  assign ix = si[PART_BITS-1:0];
  assign jx = sj[PART_BITS-1:0];
  assign nx = sn[PART_BITS-1:0];

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign pair_sum  = {1'b0, rd0} + {1'b0, rd1};
  assign edge_sum  = {1'b0, rd0} + (WEIGHT_BITS+1)'(deg);

  pps_ram #(.AW(ADDR_BITS), .DW(WEIGHT_BITS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr0, .raddr1, .rdata0(rd0), .rdata1(rd1)
  );

  pps_range_table u_ranges (
    .clk, .rst,
    .wr_en   (rt_wr),
    .wr_idx  (cmd_word.part_index),
    .wr_first(cmd_word.range_first[VERTEX_BITS-1:0]),
    .wr_last (cmd_word.range_last[VERTEX_BITS-1:0]),
    .start   (rt_start),
    .src     (cmd_word.edge_src[VERTEX_BITS-1:0]),
    .dst     (cmd_word.edge_dst[VERTEX_BITS-1:0]),
    .count   (active),
    .srch
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // next state, RAM and range table strobes
  always_comb begin
    state_next = state;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr0   = '0;
    raddr1   = '0;
    rt_wr    = 1'b0;
    rt_start = 1'b0;
    acc_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DONE;
          case (cmd_word.command)
            CMD_START: begin
              if (cmd_word.part_count != '0 && 32'(cmd_word.part_count) <= MAX_PARTS)
                state_next = S_CLEAR;
              else
                acc_status = ST_BAD;
            end
            CMD_LOAD: begin
              if (32'(cmd_word.part_index) < MAX_PARTS) rt_wr = 1'b1;
              else                                      acc_status = ST_BAD;
            end
            CMD_EDGE: begin
              rt_start   = 1'b1;
              state_next = S_EDGE_SCAN;
            end
            CMD_SELECT: if (active >= CNT_BITS'(2)) state_next = S_SEL_RD;
            CMD_SPLIT: begin
              if (CNT_BITS'(cmd_word.part_index) >= active) acc_status = ST_BAD;
              else if (32'(active) >= MAX_PARTS)           acc_status = ST_FULL;
              else                                         state_next = S_SPL_RD;
            end
            default: begin
              state_next = S_DONE;
              acc_status = ST_BAD;
            end
          endcase
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        if (clr == '1)
          state_next = clr_reply ? S_DONE : S_IDLE;
      end
      S_EDGE_SCAN: begin
        if (srch.done) begin
          if (srch.has_from && srch.has_to && srch.from_part != srch.to_part)
            state_next = S_EDGE_RD;
          else
            state_next = S_DONE;
        end
      end
      S_EDGE_RD: begin
        raddr0     = cell_addr(srch.from_part, srch.to_part);
        state_next = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        we    = 1'b1;
        waddr = cell_addr(srch.from_part, srch.to_part);
        wdata = edge_sum[WEIGHT_BITS] ? '1 : edge_sum[WEIGHT_BITS-1:0];
        state_next = S_DONE;
      end
      S_SEL_RD: begin
        raddr0     = cell_addr(ix, jx);
        raddr1     = cell_addr(jx, ix);
        state_next = S_SEL_EV;
      end
      S_SEL_EV: begin
        if (sj + 1'b1 < active || si + CNT_BITS'(2) < active)
          state_next = S_SEL_RD;
        else
          state_next = S_DONE;
      end
      S_SPL_RD: begin
        raddr0     = cell_addr(ix, sp);
        raddr1     = cell_addr(sp, ix);
        state_next = S_SPL_W0;
      end
      S_SPL_W0: begin
        we = 1'b1; waddr = cell_addr(ix, nx); wdata = rd0 >> 1;
        state_next = S_SPL_W1;
      end
      S_SPL_W1: begin
        we = 1'b1; waddr = cell_addr(nx, ix); wdata = wb >> 1;
        state_next = S_SPL_W2;
      end
      S_SPL_W2: begin
        // diagonal cell of p is halved by both the row and column pass
        we = 1'b1; waddr = cell_addr(sp, ix);
        wdata = (ix == sp) ? (wa >> 2) : (wb >> 1);
        state_next = S_SPL_W3;
      end
      S_SPL_W3: begin
        we = (ix != sp); waddr = cell_addr(ix, sp); wdata = wa >> 1;
        state_next = (si + 1'b1 < sn) ? S_SPL_RD : S_LINK0;
      end
      S_LINK0: begin
        we = 1'b1; waddr = cell_addr(sp, nx); wdata = WEIGHT_BITS'(1);
        state_next = S_LINK1;
      end
      S_LINK1: begin
        we = 1'b1; waddr = cell_addr(nx, sp); wdata = WEIGHT_BITS'(1);
        state_next = S_LINK2;
      end
      S_LINK2: begin
        we = 1'b1; waddr = cell_addr(nx, nx); wdata = '0;
        state_next = S_DONE;
      end
      S_DONE: if (!res_valid || res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and result staging
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      clr       <= '0;
      clr_reply <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // a word taken in S_DONE is replaced there by the next one
      if (res_valid && res_ready && state != S_DONE) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend <= res_word_t'({acc_status, {(BEST_BITS+2*PART_BITS+1){1'b0}}});
            deg  <= cmd_word.dst_degree;
            sp   <= cmd_word.part_index;
            sn   <= active;
            si   <= '0;
            sj   <= CNT_BITS'(1);
            if (cmd_word.command == CMD_START && state_next == S_CLEAR) begin
              active    <= CNT_BITS'(cmd_word.part_count);
              clr       <= '0;
              clr_reply <= 1'b1;
            end
          end
        end
        S_CLEAR: clr <= clr + 1'b1;
        S_EDGE_SCAN:
          if (srch.done && !(srch.has_from && srch.has_to)) pend.status <= ST_OUTSIDE;
        S_SEL_EV: begin
          if (!pend.pair_found || pair_sum > pend.best_weight) begin
            pend.pair_found  <= 1'b1;
            pend.best_weight <= pair_sum;
            pend.first_part  <= ix;
            pend.second_part <= jx;
          end
          if (sj + 1'b1 < active) begin
            sj <= sj + 1'b1;
          end else begin
            si <= si + 1'b1;
            sj <= si + CNT_BITS'(2);
          end
        end
        S_SPL_W0: begin
          wa <= rd0;
          wb <= rd1;
        end
        S_SPL_W3: si <= si + 1'b1;
        S_LINK2:  active <= sn + 1'b1;
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res_word  <= pend;
            clr_reply <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/pps_ram.sv =====
module pps_ram #(
  parameter int AW = 8,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end
endmodule

// ===== rtl/core/pps_range_table.sv =====
module pps_range_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pps_pkg::PART_BITS-1:0] wr_idx,
  input  logic [pps_pkg::VERTEX_BITS-1:0] wr_first,
  input  logic [pps_pkg::VERTEX_BITS-1:0] wr_last,
  input  logic                          start,
  input  logic [pps_pkg::VERTEX_BITS-1:0] src,
  input  logic [pps_pkg::VERTEX_BITS-1:0] dst,
  input  logic [pps_pkg::CNT_BITS-1:0]  count,
  output pps_pkg::search_t              srch
);
  import pps_pkg::*;

  logic [VERTEX_BITS-1:0] lo [MAX_PARTS];
  logic [VERTEX_BITS-1:0] hi [MAX_PARTS];
  logic                   busy;
  logic [CNT_BITS-1:0]    j;
  logic [PART_BITS-1:0]   jx;
  logic [VERTEX_BITS-1:0] src_q, dst_q;
  logic                   src_hit, dst_hit;

  assign jx      = j[PART_BITS-1:0];
  assign src_hit = (src_q >= lo[jx]) && (src_q <= hi[jx]);
  assign dst_hit = (dst_q >= lo[jx]) && (dst_q <= hi[jx]);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo[wr_idx] <= wr_first;
      hi[wr_idx] <= wr_last;
    end
  end

  // one range per cycle; later hits override earlier ones
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      j         <= '0;
      srch.done <= 1'b0;
    end else begin
      srch.done <= 1'b0;
      if (start) begin
        busy          <= 1'b1;
        j             <= '0;
        src_q         <= src;
        dst_q         <= dst;
        srch.has_from <= 1'b0;
        srch.has_to   <= 1'b0;
      end else if (busy) begin
        if (j < count) begin
          if (src_hit) begin
            srch.has_from  <= 1'b1;
            srch.from_part <= jx;
          end
          if (dst_hit) begin
            srch.has_to  <= 1'b1;
            srch.to_part <= jx;
          end
          j <= j + 1'b1;
        end else begin
          busy      <= 1'b0;
          srch.done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/pps_checker.sv =====
module pps_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input pps_pkg::res_word_t res_word,
  input logic               res_valid,
  input logic               res_ready
);
  import pps_pkg::*;

  // a pending result word holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_word))
    else $error("result word dropped or changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous one in flight");

  a_pair_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.pair_found |->
      res_word.status == ST_OK && res_word.first_part < res_word.second_part)
    else $error("bad pair report");

  a_no_pair_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_word.pair_found |->
      res_word.best_weight == '0 && res_word.first_part == '0 &&
      res_word.second_part == '0)
    else $error("pair fields set without a pair");
endmodule

bind partition_pair_scheduler pps_checker u_pps_checker (
  .clk, .rst, .cmd_valid, .cmd_ready, .res_word, .res_valid, .res_ready
);

// ===== dv/tb_partition_pair_scheduler.sv =====
`timescale 1ns / 100ps

// Testbench for partition_pair_scheduler.
// One command word in, exactly one result word out, in order. A behavioral
// copy of the weight matrix, range table and partition count predicts the results of
// untyped words; a scoreboard queue holds expected results until the DUT answers.
module tb_partition_pair_scheduler;
  import pps_pkg::*;

  localparam int          LIMIT_CYCLES = 2000000;
  localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int          ITEMS_PHASE  = 300;   // random words per idle phase
  localparam logic [2:0]  CMD_RSVD_LO  = 3'd5;  // unused command codes
  localparam logic [2:0]  CMD_RSVD_HI  = 3'd7;
  localparam logic [39:0] WEIGHT_SAT   = {WEIGHT_BITS{1'b1}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_word_t cmd_word = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_word_t res_word;

  partition_pair_scheduler dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_word(cmd_word),
    .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: mirrors the block's matrix, range table and count.
  // ---------------------------------------------------------------------
  logic [39:0] wmat [MAX_PARTS][MAX_PARTS];
  logic [31:0] rlow [MAX_PARTS];
  logic [31:0] rhigh[MAX_PARTS];
  bit          rloaded[MAX_PARTS];  // range entry written since reset
  int          nparts;

  res_word_t pending_results[$];

  int  cycles = 0;
  int  errors = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  n_split = 0, n_select = 0, n_saturated = 0;

  // idling controls, read by the driver and the receiver
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;

  function automatic res_word_t pack_result(logic [1:0] st, logic found,
                                            logic [3:0] a, logic [3:0] b,
                                            logic [40:0] w);
    res_word_t r;
    r.status = st; r.pair_found = found;
    r.first_part = a; r.second_part = b; r.best_weight = w;
    return r;
  endfunction

  function automatic cmd_word_t pack_cmd(logic [2:0] c, logic [3:0] idx,
                                         logic [4:0] cnt, logic [31:0] lo,
                                         logic [31:0] hi, logic [31:0] s,
                                         logic [31:0] d, logic [31:0] deg);
    cmd_word_t w;
    w.command = c; w.part_index = idx; w.part_count = cnt;
    w.range_first = lo; w.range_last = hi;
    w.edge_src = s; w.edge_dst = d; w.dst_degree = deg;
    return w;
  endfunction

  // Append partition n by splitting p: halved copies of row and column p,
  // link cells set to one, then row and column p halved in place.
  function automatic void split_partition(int p);
    int n;
    n = nparts;
    for (int i = 0; i < n; i++) wmat[i][n] = wmat[i][p] >> 1;
    wmat[p][n] = 40'd1;
    for (int i = 0; i < n; i++) wmat[n][i] = wmat[p][i] >> 1;
    wmat[n][n] = '0;
    wmat[n][p] = 40'd1;
    for (int i = 0; i < n; i++) begin
      wmat[p][i] = wmat[p][i] >> 1;
      wmat[i][p] = wmat[i][p] >> 1;
    end
    nparts = n + 1;
  endfunction

  // Predict the result of one accepted command word and update state.
  function automatic res_word_t predict_schedule(cmd_word_t w);
    res_word_t   r;
    bit          has_from, has_to, found;
    int          from_p, to_p, bp, bq;
    logic [40:0] best, sum;
    r = '0;
    case (w.command)
      CMD_START: begin
        if (w.part_count == 0 || w.part_count > MAX_PARTS) begin
          r.status = ST_BAD;
        end else begin
          foreach (wmat[i, j]) wmat[i][j] = '0;
          nparts = w.part_count;
        end
      end
      CMD_LOAD: begin
        // index field cannot exceed the table, so every load lands
        rlow[w.part_index]    = w.range_first;
        rhigh[w.part_index]   = w.range_last;
        rloaded[w.part_index] = 1'b1;
      end
      CMD_EDGE: begin
        has_from = 0; has_to = 0; from_p = 0; to_p = 0;
        // last matching range wins
        for (int j = 0; j < nparts; j++) begin
          if (w.edge_src >= rlow[j] && w.edge_src <= rhigh[j]) begin
            from_p = j; has_from = 1;
          end
          if (w.edge_dst >= rlow[j] && w.edge_dst <= rhigh[j]) begin
            to_p = j; has_to = 1;
          end
        end
        if (!has_from || !has_to) begin
          r.status = ST_OUTSIDE;
        end else if (from_p != to_p) begin
          if ({8'd0, w.dst_degree} > WEIGHT_SAT - wmat[from_p][to_p]) begin
            wmat[from_p][to_p] = WEIGHT_SAT;
            n_saturated++;
          end else begin
            wmat[from_p][to_p] = wmat[from_p][to_p] + w.dst_degree;
          end
        end
      end
      CMD_SELECT: begin
        found = 0; best = '0; bp = 0; bq = 0;
        for (int i = 0; i + 1 < nparts; i++) begin
          for (int j = i + 1; j < nparts; j++) begin
            sum = {1'b0, wmat[i][j]} + {1'b0, wmat[j][i]};
            if (!found || sum > best) begin
              found = 1; best = sum; bp = i; bq = j;
            end
          end
        end
        if (found) r = pack_result(ST_OK, 1'b1, bp[3:0], bq[3:0], best);
        n_select++;
      end
      CMD_SPLIT: begin
        if (w.part_index >= nparts) r.status = ST_BAD;
        else if (nparts >= MAX_PARTS) r.status = ST_FULL;
        else begin
          split_partition(w.part_index);
          n_split++;
        end
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents a word at the falling edge, holds it until taken.
  // ---------------------------------------------------------------------
  task automatic send_word(cmd_word_t w, bit typed, res_word_t typed_res);
    res_word_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    do @(posedge clk); while (!cmd_ready);
    r = predict_schedule(w);
    pending_results = {pending_results, (typed ? typed_res : r)};
    words_sent++;
  endtask

  // Random word; edges go out only when every searched range is loaded,
  // otherwise the first missing range is loaded instead.
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        roll, miss;
    logic [31:0] lo;
    w.range_first = $urandom; w.range_last = $urandom;
    w.edge_src = $urandom; w.edge_dst = $urandom; w.dst_degree = $urandom;
    w.part_index = 4'($urandom_range(15));
    w.part_count = 5'($urandom_range(31));
    roll = $urandom_range(99);
    if (roll < 7) begin
      w.command = CMD_START;
      if ($urandom_range(3) != 0) w.part_count = 5'($urandom_range(6, 2));
    end else if (roll < 20) begin
      w.command = CMD_LOAD;
      if ($urandom_range(9) < 7) begin
        lo = $urandom_range(1023);
        w.range_first = lo;
        w.range_last  = lo + $urandom_range(300);
      end
    end else if (roll < 68) begin
      w.command = CMD_EDGE;
      if ($urandom_range(9) < 8) begin
        w.edge_src = $urandom_range(1200);
        w.edge_dst = $urandom_range(1200);
      end
      case ($urandom_range(3))
        0: w.dst_degree = '1;
        1: w.dst_degree = $urandom_range(1000);
        default: ;
      endcase
    end else if (roll < 82) begin
      w.command = CMD_SELECT;
    end else if (roll < 96) begin
      w.command = CMD_SPLIT;
      if (nparts > 0 && $urandom_range(4) != 0)
        w.part_index = 4'($urandom_range(nparts - 1));
    end else begin
      w.command = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    end
    if (w.command == CMD_EDGE) begin
      miss = -1;
      for (int j = nparts - 1; j >= 0; j--) if (!rloaded[j]) miss = j;
      if (miss >= 0) begin
        w.command = CMD_LOAD;
        w.part_index = 4'(miss);
      end
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Scoreboard: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, res_word);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_word.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, res_word.status);
          errors++;
        end
        if (res_word.pair_found !== want.pair_found) begin
          $display("%0t: pair_found exp %0d got %0d", $time, want.pair_found,
                   res_word.pair_found);
          errors++;
        end
        if (res_word.first_part !== want.first_part) begin
          $display("%0t: first_part exp %0d got %0d", $time, want.first_part,
                   res_word.first_part);
          errors++;
        end
        if (res_word.second_part !== want.second_part) begin
          $display("%0t: second_part exp %0d got %0d", $time, want.second_part,
                   res_word.second_part);
          errors++;
        end
        if (res_word.best_weight !== want.best_weight) begin
          $display("%0t: best_weight exp %h got %h", $time, want.best_weight,
                   res_word.best_weight);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("tb_partition_pair_scheduler: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed table, then random phases.
  // ---------------------------------------------------------------------
  typedef struct {
    cmd_word_t w;
    bit        typed;
    res_word_t r;
  } stim_row_t;

  stim_row_t stim_rows[$];

  task automatic add_row(cmd_word_t w, bit typed, res_word_t r);
    stim_row_t row;
    row.w = w; row.typed = typed; row.r = r;
    stim_rows = {stim_rows, row};
  endtask

  initial begin : main_seq
    res_word_t ok, bad, zero;
    int        wait_left;
    foreach (wmat[i, j]) wmat[i][j] = '0;
    foreach (rlow[i]) begin
      rlow[i] = '0; rhigh[i] = '0; rloaded[i] = 1'b0;
    end
    nparts = 0;
    ok   = pack_result(ST_OK, 0, 0, 0, 0);
    bad  = pack_result(ST_BAD, 0, 0, 0, 0);
    zero = '0;

    // nothing active after reset: no pair, every edge is outside
    add_row(pack_cmd(CMD_SELECT, 0, 0, 0, 0, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_EDGE, 0, 0, 0, 0, 0, 0, 5), 1,
            pack_result(ST_OUTSIDE, 0, 0, 0, 0));
    // start counts out of range, then reserved command codes
    add_row(pack_cmd(CMD_START, 0, 0, 0, 0, 0, 0, 0), 1, bad);
    add_row(pack_cmd(CMD_START, 0, 17, 0, 0, 0, 0, 0), 1, bad);
    add_row(pack_cmd(CMD_START, 0, 31, 0, 0, 0, 0, 0), 1, bad);
    add_row(pack_cmd(CMD_RSVD_LO, 0, 4, 0, 0, 0, 0, 0), 1, bad);
    add_row(pack_cmd(CMD_RSVD_HI, 15, 31, '1, '1, '1, '1, '1), 1, bad);
    // ranges: overlap between 1 and 2, range 3 holds only the top vertex
    add_row(pack_cmd(CMD_LOAD, 0, 0, 0, 99, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_LOAD, 1, 0, 100, 199, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_LOAD, 2, 0, 150, '1, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_LOAD, 3, 0, '1, '1, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_LOAD, 15, 0, 0, 0, 0, 0, 0), 1, ok);
    // full table refuses a split; split index past the count is bad
    add_row(pack_cmd(CMD_START, 0, 16, 0, 0, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_SPLIT, 0, 0, 0, 0, 0, 0, 0), 1,
            pack_result(ST_FULL, 0, 0, 0, 0));
    add_row(pack_cmd(CMD_START, 0, 2, 0, 0, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_SPLIT, 15, 0, 0, 0, 0, 0, 0), 1, bad);
    // all-zero matrix: first pair wins
    add_row(pack_cmd(CMD_SELECT, 0, 0, 0, 0, 0, 0, 0), 1,
            pack_result(ST_OK, 1, 0, 1, 0));
    add_row(pack_cmd(CMD_START, 0, 4, 0, 0, 0, 0, 0), 1, ok);
    add_row(pack_cmd(CMD_EDGE, 0, 0, 0, 0, 5, 120, '1), 0, zero);
    add_row(pack_cmd(CMD_EDGE, 0, 0, 0, 0, 160, 0, 7), 0, zero);
    add_row(pack_cmd(CMD_EDGE, 0, 0, 0, 0, '1, 170, 1000), 0, zero);
    add_row(pack_cmd(CMD_EDGE, 0, 0, 0, 0, 50, 60, 9), 0, zero);   // same part
    add_row(pack_cmd(CMD_SELECT, 0, 0, 0, 0, 0, 0, 0), 0, zero);
    add_row(pack_cmd(CMD_SPLIT, 1, 0, 0, 0, 0, 0, 0), 0, zero);
    add_row(pack_cmd(CMD_SELECT, 0, 0, 0, 0, 0, 0, 0), 0, zero);

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[k]) send_word(stim_rows[k].w, stim_rows[k].typed, stim_rows[k].r);

    // random phases: no idling, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 33 : 0;
      for (int k = 0; k < ITEMS_PHASE; k++) begin
        if (ph == 0 && k == ITEMS_PHASE / 2) hold_req = 1'b1;
        send_word(random_word(), 0, zero);
      end
    end
    @(negedge clk);
    cmd_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    wait_left = 600;
    while (wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end

    $display("Ran %0d command words (%0d selects, %0d splits, %0d saturating edges),",
             words_sent, n_select, n_split, n_saturated);
    $display("checked %0d result words under four idle patterns and one long hold-off.",
             results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_partition_pair_scheduler: PASS");
    end else begin
      $display("tb_partition_pair_scheduler: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_range_table.sv
rtl/core/partition_pair_scheduler.sv
rtl/core/pps_checker.sv
dv/tb_partition_pair_scheduler.sv
